FILE: design/sha_message_padder_core_macros.svh
// Assertion macros for the SHA message padder.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef SHA_MESSAGE_PADDER_CORE_MACROS_SVH
`define SHA_MESSAGE_PADDER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define SHA_PAD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHA_PAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SHA_PAD_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SHA_PAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: design/sha_pad_pkg.sv
package sha_pad_pkg;

   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [3:0] LENGTH_SLOT = 4'd14;
   localparam logic [3:0] BLOCK_LAST  = 4'd15;

   // what the datapath loads into the output register
   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_DATA,
      EMIT_PAD,
      EMIT_ZERO,
      EMIT_LEN_HI,
      EMIT_LEN_LO
   } emit_type;

   typedef struct packed {
      logic     load_byte;
      logic     clear;
      emit_type emit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;        // output register can take a word this cycle
      logic byte_full;       // three bytes pending, next byte completes a word
      logic wp_before_slot;  // next word emitted lands just before the length slot
   } dp_status_type;

endpackage

FILE: design/sha_pad_ctrl.sv
module sha_pad_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tuser,
   output logic                       req_tready,
   input  sha_pad_pkg::dp_status_type status,
   output sha_pad_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_DATA,
      ST_PAD,
      ST_ZERO,
      ST_LEN_HI,
      ST_LEN_LO
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.load_byte = 1'b0;
      cmd.clear     = 1'b0;
      cmd.emit      = sha_pad_pkg::EMIT_NONE;
      case (state_ff)
         ST_DATA: begin
            req_tready = status.out_free;
            if (req_tvalid && status.out_free) begin
               if (!req_tuser) begin
                  cmd.load_byte = 1'b1;
                  if (status.byte_full) begin
                     cmd.emit = sha_pad_pkg::EMIT_DATA;
                  end
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (status.out_free) begin
               cmd.emit = sha_pad_pkg::EMIT_PAD;
               state_in = status.wp_before_slot ? ST_LEN_HI : ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (status.out_free) begin
               cmd.emit = sha_pad_pkg::EMIT_ZERO;
               state_in = status.wp_before_slot ? ST_LEN_HI : ST_ZERO;
            end
         end
         ST_LEN_HI: begin
            if (status.out_free) begin
               cmd.emit = sha_pad_pkg::EMIT_LEN_HI;
               state_in = ST_LEN_LO;
            end
         end
         ST_LEN_LO: begin
            if (status.out_free) begin
               cmd.emit  = sha_pad_pkg::EMIT_LEN_LO;
               cmd.clear = 1'b1;
               state_in  = ST_DATA;
            end
         end
         default: begin
            state_in = ST_DATA;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DATA;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/sha_pad_dp.sv
module sha_pad_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 req_tdata,
   input  sha_pad_pkg::dp_cmd_type    cmd,
   output sha_pad_pkg::dp_status_type status,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [31:0]                rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   logic [23:0] partial_ff, partial_in;
   logic [1:0]  byte_pos_ff, byte_pos_in;
   logic [3:0]  word_pos_ff, word_pos_in;
   logic [60:0] count_ff, count_in;
   logic        valid_ff, valid_in;
   logic [31:0] word_ff, word_in;
   logic        block_end_ff, block_end_in;
   logic        last_ff, last_in;
   logic [31:0] pad_word;

   // pending bytes, then 0x80, left-aligned
   always_comb begin
      case (byte_pos_ff)
         2'd0:    pad_word = {sha_pad_pkg::PAD_BYTE, 24'h0};
         2'd1:    pad_word = {partial_ff[7:0], sha_pad_pkg::PAD_BYTE, 16'h0};
         2'd2:    pad_word = {partial_ff[15:0], sha_pad_pkg::PAD_BYTE, 8'h0};
         default: pad_word = {partial_ff, sha_pad_pkg::PAD_BYTE};
      endcase
   end

   assign status.out_free       = !valid_ff || rsp_tready;
   assign status.byte_full      = (byte_pos_ff == 2'd3);
   assign status.wp_before_slot = (word_pos_ff == sha_pad_pkg::LENGTH_SLOT - 4'd1);

   always_comb begin
      partial_in   = partial_ff;
      byte_pos_in  = byte_pos_ff;
      word_pos_in  = word_pos_ff;
      count_in     = count_ff;
      valid_in     = valid_ff && !rsp_tready;
      word_in      = word_ff;
      block_end_in = block_end_ff;
      last_in      = last_ff;

      if (cmd.load_byte) begin
         count_in = count_ff + 61'd1;
         if (byte_pos_ff == 2'd3) begin
            partial_in  = 24'h0;
            byte_pos_in = 2'd0;
         end else begin
            partial_in  = {partial_ff[15:0], req_tdata};
            byte_pos_in = byte_pos_ff + 2'd1;
         end
      end

      if (cmd.emit != sha_pad_pkg::EMIT_NONE) begin
         valid_in     = 1'b1;
         block_end_in = (word_pos_ff == sha_pad_pkg::BLOCK_LAST);
         last_in      = (cmd.emit == sha_pad_pkg::EMIT_LEN_LO);
         word_pos_in  = word_pos_ff + 4'd1;
      end

      case (cmd.emit)
         sha_pad_pkg::EMIT_DATA:   word_in = {partial_ff, req_tdata};
         sha_pad_pkg::EMIT_PAD:    word_in = pad_word;
         sha_pad_pkg::EMIT_ZERO:   word_in = 32'h0;
         sha_pad_pkg::EMIT_LEN_HI: word_in = count_ff[60:29];
         sha_pad_pkg::EMIT_LEN_LO: word_in = {count_ff[28:0], 3'b000};
         default:                  word_in = word_ff;
      endcase

      if (cmd.clear) begin
         partial_in  = 24'h0;
         byte_pos_in = 2'd0;
         word_pos_in = 4'd0;
         count_in    = 61'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff  <= 24'h0;
         byte_pos_ff <= 2'd0;
         word_pos_ff <= 4'd0;
         count_ff    <= 61'd0;
         valid_ff    <= 1'b0;
      end else begin
         partial_ff  <= partial_in;
         byte_pos_ff <= byte_pos_in;
         word_pos_ff <= word_pos_in;
         count_ff    <= count_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      block_end_ff <= block_end_in;
      last_ff      <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = word_ff;
   assign rsp_tuser  = block_end_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: design/sha_message_padder_core.sv
// A byte that completes a word shows on rsp in the cycle after its transaction.
// Throughput: one data byte per cycle while the output register drains freely.
// An end transaction blocks req while the controller walks the pad, zero and length
// words through one register, one padding word per cycle while that register drains freely.
// Reset (synchronous, active high) clears the packing state, byte count and rsp_tvalid.
`include "sha_message_padder_core_macros.svh"

module sha_message_padder_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] kind: 0 data byte, 1 end of message
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] word
   output logic        rsp_tuser,   // [0] block_end
   output logic        rsp_tlast    // message_end, on the low length word
);

   // Command and status between the sequencer and the packing datapath.
   sha_pad_pkg::dp_cmd_type    cmd;
   sha_pad_pkg::dp_status_type status;

   // Controller: takes bytes while the output register is free, then steps
   // through pad word, any zero fill, length high and length low after an end.
   sha_pad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: big-endian packing, byte counter, block word index and the
   // single output register that decouples rsp from req.
   sha_pad_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // The low length word always closes a block.
   `SHA_PAD_ASSERT_NOW(a_last_ends_block, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser, "message end without block end")

   // An end transaction stops further request transactions while padding runs.
   `SHA_PAD_ASSERT_NEXT(a_end_blocks_req, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready, "request taken during padding")

   // Two message ends are never back to back on the response side.
   `SHA_PAD_ASSERT_NEXT(a_no_double_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, !(rsp_tvalid && rsp_tlast), "repeated message end")

   // A data or padding word is only emitted once the output register can take it.
   `SHA_PAD_ASSERT_NOW(a_emit_when_free, clock, reset, cmd.emit != sha_pad_pkg::EMIT_NONE, status.out_free, "word emitted into a full output register")

endmodule
